[hw/rtl/assert_macros.svh]
// Assertion macros used by the configuration decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, ignored while i_rst_n is low.
`define SIOC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sioc assertion failed");

// Next-cycle implication, sampled on i_clk, ignored while i_rst_n is low.
`define SIOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sioc assertion failed");

`endif

[hw/rtl/sioc_pkg.sv]
// Package: constants, register offsets and shared types of the configuration decoder.
package sioc_pkg;

    localparam logic [7:0] IDX_UNLOCK = 8'h33;
    localparam logic [7:0] IDX_LOCK   = 8'hcc;
    localparam logic [7:0] REG_FIRST  = 8'ha0;
    localparam int         REG_COUNT  = 6;
    localparam int         REG_OFS_W  = 3;

    // Register offsets from REG_FIRST.
    localparam logic [REG_OFS_W-1:0] REG_FSR  = 3'd0;
    localparam logic [REG_OFS_W-1:0] REG_ASR  = 3'd1;
    localparam logic [REG_OFS_W-1:0] REG_MISC = 3'd4;

    localparam logic [9:0] LPT_ADDR_A   = 10'h378;
    localparam logic [9:0] LPT_ADDR_B   = 10'h278;
    localparam logic [9:0] LPT_ADDR_C   = 10'h3bc;
    localparam logic [9:0] COM1_BASE    = 10'h3f8;
    localparam logic [9:0] COM2_BASE    = 10'h2f8;
    localparam logic [9:0] FDC_PRI_BASE = 10'h3f0;
    localparam logic [9:0] FDC_SEC_BASE = 10'h370;
    localparam logic [9:0] IDE_PRI_BASE = 10'h1f0;
    localparam logic [9:0] IDE_SEC_BASE = 10'h170;
    localparam logic [9:0] IDE_CTRL_OFS = 10'h206;

    localparam logic [9:0] COM3_SEL0 = 10'h3e8;
    localparam logic [9:0] COM4_SEL0 = 10'h2e8;
    localparam logic [9:0] COM3_SEL1 = 10'h338;
    localparam logic [9:0] COM4_SEL1 = 10'h238;
    localparam logic [9:0] COM3_SEL2 = 10'h2e8;
    localparam logic [9:0] COM4_SEL2 = 10'h2e0;
    localparam logic [9:0] COM3_SEL3 = 10'h220;
    localparam logic [9:0] COM4_SEL3 = 10'h228;

    typedef struct packed {
        logic       req_type;
        logic       port_select;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic       lpt_en;
        logic [9:0] lpt_b;
        logic       u1_en;
        logic [9:0] u1_b;
        logic       u2_en;
        logic [9:0] u2_b;
        logic       fdc_en;
        logic [9:0] fdc_b;
        logic       ide_en;
        logic [9:0] ide_b;
        logic [9:0] ide_cb;
    } t_map;

endpackage

[hw/rtl/sioc_if.sv]
// Interfaces: request, response and configuration channels of the decoder.
interface sioc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       port_select;
    logic [7:0] write_data;

    modport source (output valid, output req_type, output port_select, output write_data,
                    input ready);
    modport sink (input valid, input req_type, input port_select, input write_data,
                  output ready);
endinterface

interface sioc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       lpt_enable;
    logic [9:0] lpt_addr;
    logic       uart1_enable;
    logic [9:0] uart1_base;
    logic       uart2_enable;
    logic [9:0] uart2_base;
    logic       fdc_enable;
    logic [9:0] fdc_addr;
    logic       ide_enable;
    logic [9:0] ide_addr;
    logic [9:0] ide_control_base;

    modport source (output valid, output read_data, output lpt_enable, output lpt_addr,
                    output uart1_enable, output uart1_base, output uart2_enable,
                    output uart2_base, output fdc_enable, output fdc_addr,
                    output ide_enable, output ide_addr, output ide_control_base,
                    input ready);
    modport sink (input valid, input read_data, input lpt_enable, input lpt_addr,
                  input uart1_enable, input uart1_base, input uart2_enable,
                  input uart2_base, input fdc_enable, input fdc_addr,
                  input ide_enable, input ide_addr, input ide_control_base,
                  output ready);
endinterface

interface sioc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sioc_map_calc.sv]
// Resource map decode from the function, address and misc registers.
module sioc_map_calc (
    input  logic [7:0]      i_fsr,
    input  logic [7:0]      i_asr,
    input  logic [1:0]      i_com_sel,
    input  logic            i_ide_present,
    output sioc_pkg::t_map  o_map
);
    import sioc_pkg::*;

    logic [9:0] com3;
    logic [9:0] com4;
    logic [9:0] ide_b;

    always_comb begin
        case (i_com_sel)
            2'd0: begin
                com3 = COM3_SEL0;
                com4 = COM4_SEL0;
            end
            2'd1: begin
                com3 = COM3_SEL1;
                com4 = COM4_SEL1;
            end
            2'd2: begin
                com3 = COM3_SEL2;
                com4 = COM4_SEL2;
            end
            default: begin
                com3 = COM3_SEL3;
                com4 = COM4_SEL3;
            end
        endcase
    end

    assign ide_b = i_asr[7] ? IDE_SEC_BASE : IDE_PRI_BASE;

    always_comb begin
        o_map = '0;
        if (i_fsr[1:0] == 2'b00) begin
            o_map.lpt_en = 1'b1;
            o_map.lpt_b  = i_asr[1] ? LPT_ADDR_C : (i_asr[0] ? LPT_ADDR_B : LPT_ADDR_A);
        end
        if (i_fsr[2]) begin
            o_map.u1_en = 1'b1;
            o_map.u1_b  = i_asr[3] ? (i_asr[2] ? com4 : com3)
                                   : (i_asr[2] ? COM2_BASE : COM1_BASE);
        end
        if (i_fsr[3]) begin
            o_map.u2_en = 1'b1;
            o_map.u2_b  = i_asr[5] ? (i_asr[4] ? com4 : com3)
                                   : (i_asr[4] ? COM2_BASE : COM1_BASE);
        end
        if (i_fsr[4]) begin
            o_map.fdc_en = 1'b1;
            o_map.fdc_b  = i_asr[6] ? FDC_SEC_BASE : FDC_PRI_BASE;
        end
        if (i_ide_present && i_fsr[5]) begin
            o_map.ide_en = 1'b1;
            o_map.ide_b  = ide_b;
            o_map.ide_cb = 10'(ide_b + IDE_CTRL_OFS);
        end
    end

endmodule

[hw/rtl/sioc_regfile.sv]
// Index, lock, configuration bytes and the stored resource map.
module sioc_regfile (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  sioc_pkg::t_req  i_req,
    input  logic            i_ide_present,
    output logic [7:0]      o_rd_data,
    output sioc_pkg::t_map  o_map_next
);
    import sioc_pkg::*;

    logic [7:0]           r_index;
    logic [7:0]           n_index;
    logic                 r_locked;
    logic                 n_locked;
    logic [7:0]           r_bytes [REG_COUNT];
    logic [7:0]           n_bytes [REG_COUNT];
    t_map                 r_map;
    t_map                 n_map;
    t_map                 calc_map;
    logic                 reg_hit;
    logic [REG_OFS_W-1:0] reg_ofs;
    logic                 recompute;

    assign reg_hit = (r_index >= REG_FIRST) && (r_index < 8'(REG_FIRST + REG_COUNT));
    assign reg_ofs = REG_OFS_W'(r_index - REG_FIRST);

    // Reads change nothing; only a read of an implemented register returns data.
    assign o_rd_data = (!i_req.req_type && reg_hit) ? r_bytes[reg_ofs] : 8'h00;

    always_comb begin
        n_index   = r_index;
        n_locked  = r_locked;
        n_bytes   = r_bytes;
        recompute = 1'b0;
        if (i_acc && i_req.req_type) begin
            if (!i_req.port_select) begin
                n_index = i_req.write_data;
                if (i_req.write_data == IDX_UNLOCK) begin
                    n_locked = 1'b0;
                end else if (i_req.write_data == IDX_LOCK) begin
                    n_locked = 1'b1;
                end
            end else if (!r_locked && reg_hit) begin
                n_bytes[reg_ofs] = i_req.write_data;
                recompute = (reg_ofs == REG_FSR) || (reg_ofs == REG_ASR);
            end
        end
    end

    // COM3/COM4 choices come from the stored misc byte, so a misc write on its
    // own leaves the map alone.
    sioc_map_calc u_map_calc (
        .i_fsr        (n_bytes[REG_FSR]),
        .i_asr        (n_bytes[REG_ASR]),
        .i_com_sel    (r_bytes[REG_MISC][7:6]),
        .i_ide_present(i_ide_present),
        .o_map        (calc_map)
    );

    assign n_map      = recompute ? calc_map : r_map;
    assign o_map_next = n_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_locked <= 1'b0;
            // The function register comes out of reset as 0x03, the rest as zero.
            for (int i = 0; i < REG_COUNT; i++) begin
                r_bytes[i] <= (i == int'(REG_FSR)) ? 8'h03 : 8'h00;
            end
            r_map    <= '0;
        end else begin
            r_index  <= n_index;
            r_locked <= n_locked;
            r_bytes  <= n_bytes;
            r_map    <= n_map;
        end
    end

endmodule

[hw/rtl/superio_config_decoder.sv]
// Top level of the index/data configuration decoder with its response register.
//
// Usage: bus accesses arrive as transactions on i_req (req_type 1 = write,
// port_select 0 = index port, 1 = data port, write_data). Writing 0x33 to the
// index port unlocks the block, 0xcc locks it; while unlocked, data writes
// reach the registers at indices 0xa0..0xa5. Each request transaction yields
// exactly one response transaction on o_rsp carrying read_data (the register
// at the current index on reads, zero on writes) and the resource map as it
// stands after the access. The map is rebuilt on writes to the function and
// address registers; i_cfg sets ide_present, which is sampled at that rebuild.
// Latency: the response is valid in the cycle after the request transaction.
// Throughput: one transaction per cycle, limited only by the single response
// register; i_req.ready stays high while that register is empty or being
// taken in the same cycle. If the receiver stalls, the response holds and the
// next request waits. Reset (synchronous, active low) empties the response
// register, clears index and lock, loads 0x03 into the function register and
// leaves every function disabled with zero bases.
`include "assert_macros.svh"

module superio_config_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sioc_cfg_if.sink   i_cfg,
    sioc_req_if.sink   i_req,
    sioc_rsp_if.source o_rsp
);
    import sioc_pkg::*;

    logic       r_ide_present;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_rd_data;
    t_map       r_map;
    t_req       req;
    logic       req_acc;
    logic [7:0] rd_data;
    t_map       map_next;

    // Configuration register always writable; write only while idle; unenforced.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ide_present <= 1'b0;
        end else if (i_cfg.valid) begin
            r_ide_present <= i_cfg.data;
        end
    end

    assign req.req_type    = i_req.req_type;
    assign req.port_select = i_req.port_select;
    assign req.write_data  = i_req.write_data;

    // A new request is taken whenever the response register is free or draining.
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign req_acc     = i_req.valid && i_req.ready;

    sioc_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (req_acc),
        .i_req        (req),
        .i_ide_present(r_ide_present),
        .o_rd_data    (rd_data),
        .o_map_next   (map_next)
    );

    assign n_valid = req_acc || (r_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Response payload is loaded only with an accepted request.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_rd_data <= rd_data;
            r_map     <= map_next;
        end
    end

    assign o_rsp.valid            = r_valid;
    assign o_rsp.read_data        = r_rd_data;
    assign o_rsp.lpt_enable       = r_map.lpt_en;
    assign o_rsp.lpt_addr         = r_map.lpt_b;
    assign o_rsp.uart1_enable     = r_map.u1_en;
    assign o_rsp.uart1_base       = r_map.u1_b;
    assign o_rsp.uart2_enable     = r_map.u2_en;
    assign o_rsp.uart2_base       = r_map.u2_b;
    assign o_rsp.fdc_enable       = r_map.fdc_en;
    assign o_rsp.fdc_addr         = r_map.fdc_b;
    assign o_rsp.ide_enable       = r_map.ide_en;
    assign o_rsp.ide_addr         = r_map.ide_b;
    assign o_rsp.ide_control_base = r_map.ide_cb;

    // A write transaction always answers with zero read data.
    `SIOC_ASSERT_NEXT(a_write_reads_zero, req_acc && i_req.req_type, o_rsp.read_data == 8'h00)
    // An accepted request always produces a response in the next cycle.
    `SIOC_ASSERT_NEXT(a_req_gives_rsp, req_acc, o_rsp.valid)
    // Disabled functions report zero bases.
    `SIOC_ASSERT(a_fdc_off_zero, o_rsp.valid && !o_rsp.fdc_enable, o_rsp.fdc_addr == 10'h000)
    `SIOC_ASSERT(a_ide_off_zero, o_rsp.valid && !o_rsp.ide_enable,
                 (o_rsp.ide_addr == 10'h000) && (o_rsp.ide_control_base == 10'h000))

endmodule
